[hw/rtl/ptw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Page table walk package
// Item types, walk states and page table entry constants shared by the walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int VA_W       = 48;
   localparam int PA_W       = 52;
   localparam int WORD_W     = 64;
   localparam int WIDX_W     = 12;
   localparam int LVL_IDX_W  = 9;
   localparam int TBL_BASE_W = PA_W - 12;
   localparam int TBL_WORD_W = TBL_BASE_W + LVL_IDX_W;

   // Entry bit positions
   localparam int PTE_PRESENT_BIT = 0;
   localparam int PTE_SIZE_BIT    = 7;

   typedef enum logic {
      OP_WRITE     = 1'b0,
      OP_TRANSLATE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      LVL_TOP  = 2'd0,
      LVL_1G   = 2'd1,
      LVL_2M   = 2'd2,
      LVL_4K   = 2'd3
   } level_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   typedef struct packed {
      logic              opcode;
      logic [WIDX_W-1:0] word_index;
      logic [WORD_W-1:0] word_data;
      logic [VA_W-1:0]   virt_addr;
   } req_type;

   typedef struct packed {
      logic [PA_W-1:0] phys_addr;
      logic            fault;
   } rsp_type;

endpackage
`default_nettype wire

[hw/rtl/ptw_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ptw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/four_level_page_table_walk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Four-level page table walk
// Translates 48-bit virtual addresses through a local x86-64 page table.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: an item is taken at a clock edge with start high and
//   busy low. A write item (opcode OP_WRITE) stores word_data at word_index
//   in the table memory that same edge and gives no result; busy stays low,
//   so another item may follow in the next cycle.
//   A translate item reads one table entry per level from a single-port-read
//   memory with registered read data. The result (phys_addr, fault)
//   shows for exactly one cycle with rsp_valid high, after one table read
//   per level walked (four for a 4 KiB page, two for a 1 GiB page, one to
//   four on a fault) and the output register. busy is high
//   while the walk runs; the next item can be taken in the cycle the result
//   is shown. The dependent memory reads set how long a walk takes.
//   The receiver cannot stall; results are never held back.
//   csr_wdata sets the root table address; write it only while idle.
//   MEM_WORDS must be a power of two; table addresses wrap within it.
//   Reset clears the walk state, the result strobe and the root address.
//   The table memory is not cleared; read only entries already written.
// ----------------------------------------------------------------------------
module four_level_page_table_walk #(
   parameter int MEM_WORDS = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ptw_pkg::req_type req_item,
   output logic                  rsp_valid,
   output ptw_pkg::rsp_type      rsp_item,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [51:0]      csr_wdata
);

   import ptw_pkg::*;

   localparam int AW    = $clog2(MEM_WORDS);
   localparam int WIW   = (AW > WIDX_W) ? AW : WIDX_W;
   localparam int VAK_W = 39;

   state_type               state_ff, state_in;
   logic [1:0]              level_ff, level_in;
   logic [VAK_W-1:0]        va_ff, va_in;
   logic [TBL_BASE_W-1:0]   root_ff, root_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    accept;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [WIW-1:0]          widx_ext;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [TBL_WORD_W-1:0]   rd_word;
   logic [WORD_W-1:0]       entry;
   logic [LVL_IDX_W-1:0]    next_idx;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Table writes go straight to memory on the accept edge
   assign widx_ext = WIW'(req_item.word_index);
   assign wr_addr  = widx_ext[AW-1:0];
   assign wr_en    = accept && (req_item.opcode == OP_WRITE);

   ptw_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_item.word_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (entry)
   );

   always_comb begin
      case (level_ff)
         LVL_TOP: next_idx = va_ff[38:30];
         LVL_1G:  next_idx = va_ff[29:21];
         default: next_idx = va_ff[20:12];
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      va_in        = va_ff;
      root_in      = root_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_word      = {root_ff, req_item.virt_addr[47:39]};

      if (csr_valid && csr_ready) begin
         root_in = csr_wdata[PA_W-1:12];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.opcode == OP_TRANSLATE)) begin
               rd_en    = 1'b1;
               rd_word  = {root_ff, req_item.virt_addr[47:39]};
               va_in    = req_item.virt_addr[VAK_W-1:0];
               level_in = LVL_TOP;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!entry[PTE_PRESENT_BIT]) begin
               rsp_valid_in     = 1'b1;
               rsp_in.fault     = 1'b1;
               rsp_in.phys_addr = '0;
               state_in         = ST_IDLE;
            end else if ((level_ff == LVL_1G) && entry[PTE_SIZE_BIT]) begin
               rsp_valid_in     = 1'b1;
               rsp_in.fault     = 1'b0;
               rsp_in.phys_addr = {entry[51:30], va_ff[29:0]};
               state_in         = ST_IDLE;
            end else if ((level_ff == LVL_2M) && entry[PTE_SIZE_BIT]) begin
               rsp_valid_in     = 1'b1;
               rsp_in.fault     = 1'b0;
               rsp_in.phys_addr = {entry[51:21], va_ff[20:0]};
               state_in         = ST_IDLE;
            end else if (level_ff == LVL_4K) begin
               rsp_valid_in     = 1'b1;
               rsp_in.fault     = 1'b0;
               rsp_in.phys_addr = {entry[51:12], va_ff[11:0]};
               state_in         = ST_IDLE;
            end else begin
               // descend one level
               rd_en    = 1'b1;
               rd_word  = {entry[51:12], next_idx};
               level_in = level_ff + 2'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Table word index wraps modulo the memory size
   assign rd_addr = rd_word[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= LVL_TOP;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff  <= va_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_rsp_after_walk : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_WALK))
      else $error("result strobe without a walk in progress");

   a_fault_zero_pa : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fault) |-> (rsp_ff.phys_addr == '0))
      else $error("faulted result carries a nonzero address");

   a_translate_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.opcode == OP_TRANSLATE)) |=> busy)
      else $error("translate item did not start a walk");

   a_write_idle : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.opcode == OP_WRITE)) |=> (!busy && !rsp_valid_ff))
      else $error("write item started a walk or gave a result");

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_read_in_walk : assert property (@(posedge clock) disable iff (reset)
      (rd_en && (state_ff == ST_WALK)) |=> (state_ff == ST_WALK))
      else $error("walk left while a table read was pending");
`endif

endmodule
`default_nettype wire

[tb/four_level_page_table_walk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walk checker
// Watches the item, result and root register channels of the walker, keeps
// its own copy of the table memory and root address, predicts each
// translation and compares every result field by field, oldest first.
// ----------------------------------------------------------------------------
module four_level_page_table_walk_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire ptw_pkg::req_type req_item,
   input  wire logic             rsp_valid,
   input  wire ptw_pkg::rsp_type rsp_item,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [51:0]      csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   import ptw_pkg::*;

   localparam int WORDS      = 4096;
   localparam int SHOW_LIMIT = 10;

   logic [WORD_W-1:0] entry_mem [WORDS];
   logic [PA_W-1:0]   root_addr;
   rsp_type           expected_xlate [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic [11:0] entry_word(logic [PA_W-1:0] base,
                                              logic [LVL_IDX_W-1:0] idx);
      // base is 4 KiB aligned, so only bits 14:12 survive the wrap
      return base[14:3] + 12'(idx);
   endfunction

   function automatic rsp_type walk_tables(logic [VA_W-1:0] va);
      logic [WORD_W-1:0] pte;
      logic [PA_W-1:0]   base;
      rsp_type           outcome;
      outcome = '0;
      base    = {root_addr[PA_W-1:12], 12'h000};
      for (int lvl = 0; lvl < 4; lvl++) begin
         pte = entry_mem[entry_word(base, va[47-9*lvl -: 9])];
         if (!pte[PTE_PRESENT_BIT]) begin
            outcome.fault = 1'b1;
            return outcome;
         end
         if (lvl == int'(LVL_1G) && pte[PTE_SIZE_BIT]) begin
            outcome.phys_addr = {pte[51:30], va[29:0]};
            return outcome;
         end
         if (lvl == int'(LVL_2M) && pte[PTE_SIZE_BIT]) begin
            outcome.phys_addr = {pte[51:21], va[20:0]};
            return outcome;
         end
         base = {pte[51:12], 12'h000};
      end
      outcome.phys_addr = {base[51:12], va[11:0]};
      return outcome;
   endfunction

   task automatic note_mismatch(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
         $display("%0t: %s: expected phys_addr %h fault %b, got phys_addr %h fault %b",
                  $realtime, what, want.phys_addr, want.fault, got.phys_addr, got.fault);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         root_addr = '0;
         expected_xlate.delete();
      end else begin
         if (csr_valid && csr_ready)
            root_addr = csr_wdata;
         if (rsp_valid) begin
            if (expected_xlate.size() == 0) begin
               note_mismatch("result with nothing expected", '0, rsp_item);
            end else begin
               want = expected_xlate.pop_front();
               if (rsp_item.phys_addr !== want.phys_addr || rsp_item.fault !== want.fault)
                  note_mismatch("translation mismatch", want, rsp_item);
            end
         end
         // take the item after the result: the next item may enter on the result cycle
         if (start && !busy) begin
            if (req_item.opcode == OP_WRITE)
               entry_mem[req_item.word_index] = req_item.word_data;
            else
               expected_xlate.push_back(walk_tables(req_item.virt_addr));
         end
      end
      pending_count = expected_xlate.size();
   end

endmodule

[tb/four_level_page_table_walk_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walk testbench
// Drives table writes and translations into the walker, builds each walk path
// before translating so no unwritten entry is read, switches the root address
// between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module four_level_page_table_walk_tb;
   import ptw_pkg::*;

   localparam int WORDS       = 4096;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int IDLE_LIMIT  = 1000;
   localparam int POOL_SIZE   = 16;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   req_type     req_item  = '0;
   logic        csr_valid = 1'b0;
   logic [51:0] csr_wdata = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_ready;
   int          fail_count;
   int          pending_count;

   // stimulus-side view of the table, used only to plan safe walks
   logic [WORD_W-1:0] plan_mem [WORDS];
   logic              plan_written [WORDS];
   logic [PA_W-1:0]   plan_root = '0;
   logic [VA_W-1:0]   va_pool [POOL_SIZE];
   int                pool_fill  = 0;
   int                items_sent = 0;
   int                quiet_left = 0;
   int                idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   four_level_page_table_walk u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   four_level_page_table_walk_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   wire moved = (start && !busy) || rsp_valid || (csr_valid && csr_ready);

   always @(posedge clock) begin
      if (reset || moved) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [WORD_W-1:0] make_entry();
      logic [WORD_W-1:0] pte;
      pte                  = rand64();
      pte[PTE_PRESENT_BIT] = ($urandom_range(0, 7) != 0);
      pte[PTE_SIZE_BIT]    = ($urandom_range(0, 3) == 0);
      return pte;
   endfunction

   function automatic logic [VA_W-1:0] make_va(int t, int a, int b, int c, int off);
      return {9'(t), 9'(a), 9'(b), 9'(c), 12'(off)};
   endfunction

   // present an item and hold it until the block takes it
   task automatic send_item(req_type it);
      int gap;
      if (quiet_left > 0) begin
         gap = 0;
         quiet_left--;
      end else begin
         gap = $urandom_range(0, 16);
         if ($urandom_range(0, 40) == 0)
            quiet_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(negedge clock); while (busy);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic put_word(logic [11:0] idx, logic [WORD_W-1:0] data);
      req_type it;
      it            = '0;
      it.opcode     = OP_WRITE;
      it.word_index = idx;
      it.word_data  = data;
      it.virt_addr  = VA_W'(rand64());
      plan_mem[idx]     = data;
      plan_written[idx] = 1'b1;
      send_item(it);
   endtask

   // fill in every entry the walk will read that has not been written yet
   task automatic prepare_walk(logic [VA_W-1:0] va);
      logic [PA_W-1:0]   base;
      logic [11:0]       w;
      logic [WORD_W-1:0] pte;
      logic              done;
      base = {plan_root[PA_W-1:12], 12'h000};
      done = 1'b0;
      for (int lvl = 0; lvl < 4 && !done; lvl++) begin
         w = base[14:3] + 12'(va[47-9*lvl -: 9]);
         if (!plan_written[w])
            put_word(w, make_entry());
         pte = plan_mem[w];
         if (!pte[PTE_PRESENT_BIT])
            done = 1'b1;
         else if ((lvl == int'(LVL_1G) || lvl == int'(LVL_2M)) && pte[PTE_SIZE_BIT])
            done = 1'b1;
         else
            base = {pte[51:12], 12'h000};
      end
   endtask

   task automatic translate(logic [VA_W-1:0] va);
      req_type it;
      prepare_walk(va);
      it            = '0;
      it.opcode     = OP_TRANSLATE;
      it.word_index = 12'(rand64());
      it.word_data  = rand64();
      it.virt_addr  = va;
      send_item(it);
   endtask

   // drain all results, then let the block settle before touching the root
   task automatic write_root(logic [PA_W-1:0] value);
      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0 || busy);
      repeat (6) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      plan_root = value;
   endtask

   task automatic random_item();
      logic [VA_W-1:0] va;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         if (pool_fill > 0 && $urandom_range(0, 1) == 1) begin
            // revisit a known path, sometimes off in the lower levels
            va = va_pool[$urandom_range(0, pool_fill - 1)];
            va[11:0] = 12'($urandom);
            if ($urandom_range(0, 2) == 0)
               va[20:12] = 9'($urandom_range(0, 3));
         end else begin
            va = VA_W'(rand64());
            if ($urandom_range(0, 1) == 1) begin
               va[47:39] = 9'($urandom_range(0, 3));
               va[38:30] = 9'($urandom_range(0, 3));
               va[29:21] = 9'($urandom_range(0, 3));
            end
         end
         if (pool_fill < POOL_SIZE) begin
            va_pool[pool_fill] = va;
            pool_fill++;
         end else begin
            va_pool[$urandom_range(0, POOL_SIZE - 1)] = va;
         end
         translate(va);
      end else if (pick < 85) begin
         put_word(12'($urandom), make_entry());
      end else begin
         put_word(12'($urandom), rand64());
      end
   endtask

   initial begin
      logic [PA_W-1:0] root_value;
      int              phase_end;
      for (int i = 0; i < WORDS; i++)
         plan_written[i] = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // top entry absent
      put_word(12'd0, 64'h0);
      translate(make_va(0, 0, 0, 0, 0));
      // top entry with size bit and high bits set, next table at word 512
      put_word(12'd1, 64'hFFF0_0000_0000_1081);
      put_word(12'd512, 64'h0);
      translate(make_va(1, 0, 0, 0, 'h123));
      // 1 GiB page, all entry bits set
      put_word(12'd513, '1);
      translate(make_va(1, 1, 511, 511, 'hFFF));
      // third level absent, then a 2 MiB page
      put_word(12'd514, 64'h0000_0000_0000_2001);
      put_word(12'd1024, 64'h0);
      translate(make_va(1, 2, 0, 0, 0));
      put_word(12'd1025, '1);
      translate(make_va(1, 2, 1, 5, 'hABC));
      // last level absent, then a 4 KiB page with the size bit ignored
      put_word(12'd1026, 64'h0000_0000_0000_3001);
      put_word(12'd1536, 64'h0);
      translate(make_va(1, 2, 2, 0, 'h7));
      put_word(12'd1537, '1);
      translate(make_va(1, 2, 2, 1, 'hFFF));
      // table base with upper bits that wrap away, last word of memory
      put_word(12'd515, 64'h7FFF_FFFF_FFFF_F001);
      put_word(12'd4095, 64'h800F_FFFF_FFE0_1F81);
      translate(make_va(1, 3, 511, 0, 'h5A5));
      translate('1);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       root_value = '1;
            1:       root_value = '0;
            default: root_value = PA_W'(rand64());
         endcase
         write_root(root_value);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end)
            random_item();
      end

      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[four_level_page_table_walk.f]
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_ram.sv
hw/rtl/four_level_page_table_walk.sv
tb/four_level_page_table_walk_checker.sv
tb/four_level_page_table_walk_tb.sv
